>>> sv/utp_pkg.sv
// Shared widths, constants and the status code type of the UUID text parser.
// No dependencies; every other file refers to it by scoped names.
`timescale 1ns / 1ps

package utp_pkg;

    localparam int CharW   = 8;
    localparam int HalfW   = 64;
    localparam int StatusW = 3;
    localparam int CountW  = 6;
    localparam int NibbleW = 4;
    localparam int Digits  = 32;
    localparam int DigitIdxW = $clog2(Digits);

    localparam logic [CountW-1:0] TextLen   = 6'd36;
    localparam logic [CountW-1:0] DigitsMax = 6'd32;
    localparam logic [CountW-1:0] CountSat  = 6'd37;

    // Positions of the four hyphens in the canonical text
    localparam logic [CountW-1:0] HyphenPos0 = 6'd8;
    localparam logic [CountW-1:0] HyphenPos1 = 6'd13;
    localparam logic [CountW-1:0] HyphenPos2 = 6'd18;
    localparam logic [CountW-1:0] HyphenPos3 = 6'd23;

    localparam logic [CharW-1:0]   HyphenChar = 8'h2D;
    localparam logic [NibbleW-1:0] VersionWanted = 4'd7;
    localparam int                 VersionSlot = 12;

    typedef enum logic [StatusW-1:0] {
        ST_OK          = 3'd0,
        ST_BAD_LENGTH  = 3'd1,
        ST_BAD_HYPHEN  = 3'd2,
        ST_BAD_HEX     = 3'd3,
        ST_BAD_VERSION = 3'd4
    } status_t;

endpackage

>>> sv/utp_char_if.sv
// Character channel of the UUID text parser: valid, ready, one character and an end mark.
// Depends on utp_pkg for the field widths.
`timescale 1ns / 1ps

interface utp_char_if;
    logic                      valid;
    logic                      ready;
    logic [utp_pkg::CharW-1:0] ch;
    logic                      is_end;

    modport source (output valid, output ch, output is_end, input ready);
    modport sink   (input valid, input ch, input is_end, output ready);
endinterface

>>> sv/utp_result_if.sv
// Result channel of the UUID text parser: valid, ready, the 128-bit value and a status.
// Depends on utp_pkg for the field widths.
`timescale 1ns / 1ps

interface utp_result_if;
    logic                        valid;
    logic                        ready;
    logic [utp_pkg::HalfW-1:0]   uuid_upper;
    logic [utp_pkg::HalfW-1:0]   uuid_lower;
    logic [utp_pkg::StatusW-1:0] status;

    modport source (output valid, output uuid_upper, output uuid_lower, output status,
                    input ready);
    modport sink   (input valid, input uuid_upper, input uuid_lower, input status,
                    output ready);
endinterface

>>> sv/uuid_text_parser.sv
// UUID text parser: one character beat per cycle, a result beat after each end beat.
// A result is registered: an accepted end beat passes the input stage, then loads the result register.
// Throughput: one beat per cycle, set by the single input register stage; an end beat
// waits in that stage only while the result register still holds an untaken result.
// Reset: all counters, flags, digit slots and valid bits clear; mode_reg resets to strict.
// Depends on utp_pkg, utp_char_if and utp_result_if.
`timescale 1ns / 1ps

module uuid_text_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  logic                wr_data,
    utp_char_if.sink            chars,
    utp_result_if.source        result
);

    // Returns {is_hex, value}
    function automatic logic [utp_pkg::NibbleW:0] hex_decode(input logic [utp_pkg::CharW-1:0] c);
        logic [utp_pkg::NibbleW:0] r;
        r = '0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            r = {1'b1, 4'(c - 8'h30)};
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            r = {1'b1, 4'(c - 8'h61 + 8'd10)};
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            r = {1'b1, 4'(c - 8'h41 + 8'd10)};
        end
        return r;
    endfunction

    logic mode_reg;

    // Input stage
    logic                      stage_valid_reg;
    logic [utp_pkg::CharW-1:0] stage_ch_reg;
    logic                      stage_end_reg;

    // Parse state
    logic [utp_pkg::CountW-1:0]  char_count_reg, char_count_next;
    logic [utp_pkg::CountW-1:0]  digit_count_reg, digit_count_next;
    logic                        format_flag_reg, format_flag_next;
    logic                        hex_flag_reg, hex_flag_next;
    logic [utp_pkg::NibbleW-1:0] nib_reg [utp_pkg::Digits];

    // Result register
    logic                        out_valid_reg, out_valid_next;
    logic [utp_pkg::HalfW-1:0]   upper_reg, lower_reg;
    utp_pkg::status_t            status_reg;

    logic                        out_free;
    logic                        stage_go;
    logic                        take_end;
    logic                        put_en;
    logic [utp_pkg::NibbleW-1:0] put_val;
    logic [utp_pkg::NibbleW:0]   hex;
    logic                        is_hyphen_slot;
    logic                        room;
    utp_pkg::status_t            status_calc;
    logic [utp_pkg::HalfW-1:0]   upper_calc, lower_calc;

    assign out_free     = !out_valid_reg || result.ready;
    assign stage_go     = stage_valid_reg && (!stage_end_reg || out_free);
    assign take_end     = stage_go && stage_end_reg;
    assign chars.ready  = !stage_valid_reg || stage_go;

    assign hex  = hex_decode(stage_ch_reg);
    assign room = digit_count_reg < utp_pkg::DigitsMax;
    assign is_hyphen_slot = (char_count_reg == utp_pkg::HyphenPos0)
                         || (char_count_reg == utp_pkg::HyphenPos1)
                         || (char_count_reg == utp_pkg::HyphenPos2)
                         || (char_count_reg == utp_pkg::HyphenPos3);

    always_comb
    begin
        char_count_next  = char_count_reg;
        digit_count_next = digit_count_reg;
        format_flag_next = format_flag_reg;
        hex_flag_next    = hex_flag_reg;
        put_en           = 1'b0;
        put_val          = hex[utp_pkg::NibbleW-1:0];

        if (stage_go && stage_end_reg)
        begin
            char_count_next  = '0;
            digit_count_next = '0;
            format_flag_next = 1'b0;
            hex_flag_next    = 1'b0;
        end
        else if (stage_go)
        begin
            if (char_count_reg != utp_pkg::CountSat)
            begin
                char_count_next = char_count_reg + 6'd1;
            end
            if (!mode_reg)
            begin
                if (char_count_reg < utp_pkg::TextLen)
                begin
                    if (is_hyphen_slot)
                    begin
                        if (stage_ch_reg != utp_pkg::HyphenChar)
                        begin
                            format_flag_next = 1'b1;
                        end
                    end
                    else
                    begin
                        // a bad character still takes a digit slot, as zero
                        if (!hex[utp_pkg::NibbleW])
                        begin
                            hex_flag_next = 1'b1;
                            put_val       = '0;
                        end
                        put_en = room;
                    end
                end
            end
            else if (room && stage_ch_reg != utp_pkg::HyphenChar)
            begin
                if (!hex[utp_pkg::NibbleW])
                begin
                    hex_flag_next = 1'b1;
                end
                else
                begin
                    put_en = 1'b1;
                end
            end
            if (put_en)
            begin
                digit_count_next = digit_count_reg + 6'd1;
            end
        end
    end

    always_comb
    begin
        if (!mode_reg)
        begin
            if (char_count_reg != utp_pkg::TextLen)
            begin
                status_calc = utp_pkg::ST_BAD_LENGTH;
            end
            else if (format_flag_reg)
            begin
                status_calc = utp_pkg::ST_BAD_HYPHEN;
            end
            else if (hex_flag_reg)
            begin
                status_calc = utp_pkg::ST_BAD_HEX;
            end
            else if (nib_reg[utp_pkg::VersionSlot] != utp_pkg::VersionWanted)
            begin
                status_calc = utp_pkg::ST_BAD_VERSION;
            end
            else
            begin
                status_calc = utp_pkg::ST_OK;
            end
        end
        else
        begin
            if (hex_flag_reg)
            begin
                status_calc = utp_pkg::ST_BAD_HEX;
            end
            else if (digit_count_reg != utp_pkg::DigitsMax)
            begin
                status_calc = utp_pkg::ST_BAD_LENGTH;
            end
            else if (nib_reg[utp_pkg::VersionSlot] != utp_pkg::VersionWanted)
            begin
                status_calc = utp_pkg::ST_BAD_VERSION;
            end
            else
            begin
                status_calc = utp_pkg::ST_OK;
            end
        end
    end

    // Pack digits big-endian: slot 0 lands in the top nibble of the upper half
    always_comb
    begin
        for (int i = 0; i < utp_pkg::Digits / 2; i++)
        begin
            upper_calc[utp_pkg::HalfW-1-utp_pkg::NibbleW*i -: utp_pkg::NibbleW] = nib_reg[i];
            lower_calc[utp_pkg::HalfW-1-utp_pkg::NibbleW*i -: utp_pkg::NibbleW] =
                nib_reg[i + utp_pkg::Digits / 2];
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (take_end)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= 1'b0;
            stage_valid_reg <= 1'b0;
            char_count_reg  <= '0;
            digit_count_reg <= '0;
            format_flag_reg <= 1'b0;
            hex_flag_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                mode_reg <= wr_data;
            end
            if (chars.ready)
            begin
                stage_valid_reg <= chars.valid;
            end
            char_count_reg  <= char_count_next;
            digit_count_reg <= digit_count_next;
            format_flag_reg <= format_flag_next;
            hex_flag_reg    <= hex_flag_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Digit slots: cleared at reset and after every result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < utp_pkg::Digits; i++)
            begin
                nib_reg[i] <= '0;
            end
        end
        else if (take_end)
        begin
            for (int i = 0; i < utp_pkg::Digits; i++)
            begin
                nib_reg[i] <= '0;
            end
        end
        else if (put_en)
        begin
            nib_reg[digit_count_reg[utp_pkg::DigitIdxW-1:0]] <= put_val;
        end
    end

    always_ff @(posedge clk)
    begin
        if (chars.ready && chars.valid)
        begin
            stage_ch_reg  <= chars.ch;
            stage_end_reg <= chars.is_end;
        end
        if (take_end)
        begin
            status_reg <= status_calc;
            upper_reg  <= (status_calc == utp_pkg::ST_OK) ? upper_calc : '0;
            lower_reg  <= (status_calc == utp_pkg::ST_OK) ? lower_calc : '0;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.uuid_upper = upper_reg;
    assign result.uuid_lower = lower_reg;
    assign result.status     = status_reg;

`ifndef SYNTH
    a_digit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        digit_count_reg <= utp_pkg::DigitsMax && char_count_reg <= utp_pkg::CountSat)
        else $error("parse counter past its bound");

    a_clear_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        take_end |=> (char_count_reg == '0 && digit_count_reg == '0
                      && !format_flag_reg && !hex_flag_reg))
        else $error("parse state not cleared after end beat");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg != utp_pkg::ST_OK) |->
        (upper_reg == '0 && lower_reg == '0))
        else $error("nonzero value on error result");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result.ready) |-> !take_end)
        else $error("result register overwritten while stalled");
`endif

endmodule
